/* design/ssfh_pkg.sv */
// Shared widths, reset values, register codes and pipeline types of the segment-sphere test.
`default_nettype none
package ssfh_pkg;

  localparam int CoordW  = 32;            // Q16.16 coordinate
  localparam int DiffW   = CoordW + 1;    // coordinate difference
  localparam int RadW    = 31;            // radius
  localparam int ProdW   = 2 * DiffW;     // product of two differences
  localparam int SumW    = 68;            // a, c, dot product and c - r^2
  localparam int HalfW   = SumW / 2;      // half of a magnitude for the split products
  localparam int DiscW   = 4 * HalfW;     // discriminant
  localparam int RootW   = DiscW / 2;     // square root of the discriminant
  localparam int NumW    = SumW + 2;      // root numerator
  localparam int QuotW   = 32;            // quotient bits below saturation
  localparam int ParamW  = QuotW + 2;     // signed root parameter in Q4.30
  localparam int MulW    = DiffW + CoordW; // d * t
  localparam int PosW    = CoordW + 4;    // hit point before clamping

  localparam int PaddrW  = 4;
  localparam int PdataW  = 32;
  localparam int LimitW  = 32;
  localparam int MarginW = 31;
  localparam int HighW   = 31;

  localparam logic [LimitW-1:0]  LimitReset  = 32'd4295;
  localparam logic [MarginW-1:0] MarginReset = 31'd1074;
  localparam logic [HighW-1:0]   HighReset   = 31'd1073849198;

  typedef enum logic [1:0] {
    REG_LIMIT  = 2'd0,
    REG_MARGIN = 2'd1,
    REG_HIGH   = 2'd2
  } reg_idx_t;

  // Per-item data that travels alongside the square root and divider stages.
  typedef struct packed {
    logic signed [2:0][CoordW-1:0] s;
    logic signed [2:0][DiffW-1:0]  d;
    logic [SumW-1:0]               a;
    logic signed [SumW-1:0]        dt;
    logic                          deg;
    logic                          in0;
    logic                          dneg;
    logic                          az;
  } side_t;

  typedef struct packed {
    logic lo_neg;
    logic lo_sat;
    logic hi_neg;
    logic hi_sat;
  } div_tag_t;

endpackage
`default_nettype wire

/* design/ssfh_if.sv */
// Request and result channel interfaces of the segment-sphere test.
`default_nettype none
interface ssfh_query_if;
  logic                                valid;
  logic                                ready;
  logic signed [ssfh_pkg::CoordW-1:0]  start_x;
  logic signed [ssfh_pkg::CoordW-1:0]  start_y;
  logic signed [ssfh_pkg::CoordW-1:0]  start_z;
  logic signed [ssfh_pkg::CoordW-1:0]  end_x;
  logic signed [ssfh_pkg::CoordW-1:0]  end_y;
  logic signed [ssfh_pkg::CoordW-1:0]  end_z;
  logic signed [ssfh_pkg::CoordW-1:0]  center_x;
  logic signed [ssfh_pkg::CoordW-1:0]  center_y;
  logic signed [ssfh_pkg::CoordW-1:0]  center_z;
  logic [ssfh_pkg::RadW-1:0]           sphere_radius;
  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  center_x, center_y, center_z, sphere_radius, input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                center_x, center_y, center_z, sphere_radius, output ready);
endinterface

interface ssfh_result_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic signed [ssfh_pkg::CoordW-1:0]  hit_x;
  logic signed [ssfh_pkg::CoordW-1:0]  hit_y;
  logic signed [ssfh_pkg::CoordW-1:0]  hit_z;
  modport source (output valid, hit, hit_x, hit_y, hit_z, input ready);
  modport sink (input valid, hit, hit_x, hit_y, hit_z, output ready);
endinterface
`default_nettype wire

/* design/segment_sphere_first_hit.sv */
// Segment against solid sphere first-hit test: pipeline, registers and output stage.
// Usage: each request on the query channel carries a segment start and end, a sphere
// centre and a radius, all Q16.16. Exactly one result leaves on the result channel per
// request, in request order: hit plus the entry point, the exit point when the start is
// inside, or the start when the whole segment is inside; a miss returns all zeros.
// Both channels use valid/ready; a request or result moves when both are high.
// Throughput: one request per cycle while no result stall holds the pipeline, with no dependence
// between requests. The pipeline depth is set mainly by the 68-stage square root and the
// 32-stage dividers.
// Stalls: when a finished result is not taken, the whole pipeline holds in place and
// query.ready drops; nothing is lost or repeated, and bubbles are passed through.
// Registers (APB, byte addresses 0, 4, 8): degenerate length limit, low margin and
// high limit for the root parameter. Write them only while the pipeline is empty.
// Reset: synchronous, clears all valid bits and loads the register defaults.
`default_nettype none
module segment_sphere_first_hit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  ssfh_query_if.sink                         query,
  ssfh_result_if.source                      result,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ssfh_pkg::PaddrW-1:0]   paddr,
  input  wire logic [ssfh_pkg::PdataW-1:0]   pwdata,
  output logic      [ssfh_pkg::PdataW-1:0]   prdata,
  output logic                               pready
);
  localparam int CW = ssfh_pkg::CoordW;
  localparam int DW = ssfh_pkg::DiffW;
  localparam int PW = ssfh_pkg::ProdW;
  localparam int SW = ssfh_pkg::SumW;
  localparam int HW = ssfh_pkg::HalfW;
  localparam int XW = ssfh_pkg::DiscW;
  localparam int RtW = ssfh_pkg::RootW;
  localparam int NW = ssfh_pkg::NumW;
  localparam int QW = ssfh_pkg::QuotW;
  localparam int TW = ssfh_pkg::ParamW;
  localparam int MW = ssfh_pkg::MulW;
  localparam int VW = ssfh_pkg::PosW;
  localparam logic signed [MW-1:0] RoundHalf = MW'(1) << 29;
  localparam logic signed [VW-1:0] PosMax    = VW'(32'h7fff_ffff);
  localparam logic signed [VW-1:0] NegMin    = -(VW'(1) << (CW - 1));

  // Configuration registers.
  logic [ssfh_pkg::LimitW-1:0]  limit;
  logic [ssfh_pkg::MarginW-1:0] margin;
  logic [ssfh_pkg::HighW-1:0]   high;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit  <= ssfh_pkg::LimitReset;
      margin <= ssfh_pkg::MarginReset;
      high   <= ssfh_pkg::HighReset;
    end else if (psel && penable && pwrite) begin
      case (ssfh_pkg::reg_idx_t'(paddr[3:2]))
        ssfh_pkg::REG_LIMIT:  limit  <= pwdata;
        ssfh_pkg::REG_MARGIN: margin <= pwdata[ssfh_pkg::MarginW-1:0];
        ssfh_pkg::REG_HIGH:   high   <= pwdata[ssfh_pkg::HighW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ssfh_pkg::reg_idx_t'(paddr[3:2]))
      ssfh_pkg::REG_LIMIT:  prdata = limit;
      ssfh_pkg::REG_MARGIN: prdata = {1'b0, margin};
      ssfh_pkg::REG_HIGH:   prdata = {1'b0, high};
      default:              prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  // The whole pipeline advances together unless the output holds an untaken result.
  logic o_v;
  logic en;
  assign en          = !o_v || result.ready;
  assign query.ready = en;

  logic signed [CW-1:0] in_s [3];
  logic signed [CW-1:0] in_e [3];
  logic signed [CW-1:0] in_c [3];
  assign in_s[0] = query.start_x;
  assign in_s[1] = query.start_y;
  assign in_s[2] = query.start_z;
  assign in_e[0] = query.end_x;
  assign in_e[1] = query.end_y;
  assign in_e[2] = query.end_z;
  assign in_c[0] = query.center_x;
  assign in_c[1] = query.center_y;
  assign in_c[2] = query.center_z;

  // Stage 1: differences.
  logic v1;
  logic signed [CW-1:0] s1_s [3];
  logic signed [DW-1:0] s1_d [3];
  logic signed [DW-1:0] s1_f [3];
  logic [ssfh_pkg::RadW-1:0] s1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_s[i] <= in_s[i];
        s1_d[i] <= DW'(in_e[i]) - DW'(in_s[i]);
        s1_f[i] <= DW'(in_s[i]) - DW'(in_c[i]);
      end
      s1_r <= query.sphere_radius;
    end
  end

  // Stage 2: products.
  logic v2;
  logic signed [CW-1:0] s2_s [3];
  logic signed [DW-1:0] s2_d [3];
  logic signed [PW-1:0] s2_dd [3];
  logic signed [PW-1:0] s2_ff [3];
  logic signed [PW-1:0] s2_df [3];
  logic [2*ssfh_pkg::RadW-1:0] s2_rr;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_s[i]  <= s1_s[i];
        s2_d[i]  <= s1_d[i];
        s2_dd[i] <= s1_d[i] * s1_d[i];
        s2_ff[i] <= s1_f[i] * s1_f[i];
        s2_df[i] <= s1_d[i] * s1_f[i];
      end
      s2_rr <= s1_r * s1_r;
    end
  end

  // Stage 3: sums, the degenerate test and the inside-start test.
  logic v3;
  logic signed [CW-1:0] s3_s [3];
  logic signed [DW-1:0] s3_d [3];
  logic signed [SW-1:0] s3_a, s3_dt, s3_cr;
  logic s3_deg, s3_in0;
  logic signed [SW-1:0] a_sum, c_sum, dt_sum, rr_ext;

  always_comb begin
    a_sum  = SW'(s2_dd[0]) + SW'(s2_dd[1]) + SW'(s2_dd[2]);
    c_sum  = SW'(s2_ff[0]) + SW'(s2_ff[1]) + SW'(s2_ff[2]);
    dt_sum = SW'(s2_df[0]) + SW'(s2_df[1]) + SW'(s2_df[2]);
    rr_ext = $signed(SW'(s2_rr));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_s   <= s2_s;
      s3_d   <= s2_d;
      s3_a   <= a_sum;
      s3_dt  <= dt_sum;
      s3_cr  <= c_sum - rr_ext;
      s3_deg <= a_sum < $signed(SW'(limit));
      s3_in0 <= c_sum < rr_ext;
    end
  end

  // Stage 4: magnitudes for the split products.
  logic v4;
  logic signed [CW-1:0] s4_s [3];
  logic signed [DW-1:0] s4_d [3];
  logic [SW-1:0] s4_a, s4_dtm, s4_crm;
  logic signed [SW-1:0] s4_dt;
  logic s4_crn, s4_deg, s4_in0, s4_az;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_s   <= s3_s;
      s4_d   <= s3_d;
      s4_a   <= s3_a;
      s4_dt  <= s3_dt;
      s4_dtm <= s3_dt[SW-1] ? -s3_dt : s3_dt;
      s4_crm <= s3_cr[SW-1] ? -s3_cr : s3_cr;
      s4_crn <= s3_cr[SW-1];
      s4_deg <= s3_deg;
      s4_in0 <= s3_in0;
      s4_az  <= (s3_a == '0);
    end
  end

  // Stage 5: partial products of dt*dt and a*|c - r^2|.
  logic v5;
  logic signed [CW-1:0] s5_s [3];
  logic signed [DW-1:0] s5_d [3];
  logic [SW-1:0] s5_a;
  logic signed [SW-1:0] s5_dt;
  logic [2*HW-1:0] s5_ll, s5_lh, s5_hh, s5_al_cl, s5_al_ch, s5_ah_cl, s5_ah_ch;
  logic s5_crn, s5_deg, s5_in0, s5_az;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_s     <= s4_s;
      s5_d     <= s4_d;
      s5_a     <= s4_a;
      s5_dt    <= s4_dt;
      s5_ll    <= s4_dtm[HW-1:0] * s4_dtm[HW-1:0];
      s5_lh    <= s4_dtm[HW-1:0] * s4_dtm[SW-1:HW];
      s5_hh    <= s4_dtm[SW-1:HW] * s4_dtm[SW-1:HW];
      s5_al_cl <= s4_a[HW-1:0] * s4_crm[HW-1:0];
      s5_al_ch <= s4_a[HW-1:0] * s4_crm[SW-1:HW];
      s5_ah_cl <= s4_a[SW-1:HW] * s4_crm[HW-1:0];
      s5_ah_ch <= s4_a[SW-1:HW] * s4_crm[SW-1:HW];
      s5_crn   <= s4_crn;
      s5_deg   <= s4_deg;
      s5_in0   <= s4_in0;
      s5_az    <= s4_az;
    end
  end

  // Stage 6: assemble the two wide products.
  logic v6;
  logic signed [CW-1:0] s6_s [3];
  logic signed [DW-1:0] s6_d [3];
  logic [SW-1:0] s6_a;
  logic signed [SW-1:0] s6_dt;
  logic [XW-1:0] s6_dt2, s6_acr;
  logic s6_crn, s6_deg, s6_in0, s6_az;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_s   <= s5_s;
      s6_d   <= s5_d;
      s6_a   <= s5_a;
      s6_dt  <= s5_dt;
      s6_dt2 <= {s5_hh, {(2*HW){1'b0}}} + XW'({s5_lh, {(HW+1){1'b0}}}) + XW'(s5_ll);
      s6_acr <= {s5_ah_ch, {(2*HW){1'b0}}} + XW'({s5_al_ch, {HW{1'b0}}})
              + XW'({s5_ah_cl, {HW{1'b0}}}) + XW'(s5_al_cl);
      s6_crn <= s5_crn;
      s6_deg <= s5_deg;
      s6_in0 <= s5_in0;
      s6_az  <= s5_az;
    end
  end

  // Stage 7: discriminant.
  logic v7;
  logic [XW-1:0] s7_rad;
  ssfh_pkg::side_t s7_side;
  logic [XW:0] disc_diff;
  assign disc_diff = {1'b0, s6_dt2} - {1'b0, s6_acr};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s7_side.s[i] <= s6_s[i];
        s7_side.d[i] <= s6_d[i];
      end
      s7_side.a   <= s6_a;
      s7_side.dt  <= s6_dt;
      s7_side.deg <= s6_deg;
      s7_side.in0 <= s6_in0;
      s7_side.az  <= s6_az;
      if (s6_crn) begin
        s7_rad       <= s6_dt2 + s6_acr;
        s7_side.dneg <= 1'b0;
      end else begin
        s7_rad       <= disc_diff[XW-1:0];
        s7_side.dneg <= disc_diff[XW];
      end
    end
  end

  // Square root, with the item's other data in a matching delay line.
  logic [RtW-1:0] sq_root;
  ssfh_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (s7_rad),
    .root     (sq_root)
  );

  ssfh_pkg::side_t sq_side [RtW];
  logic [RtW-1:0]  sq_v;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side[0] <= s7_side;
      for (int k = 1; k < RtW; k++) begin
        sq_side[k] <= sq_side[k-1];
      end
    end
  end

  // Numerators of both roots.
  logic n1_v;
  ssfh_pkg::side_t n1_side;
  logic signed [NW-1:0] n1_lo, n1_hi, ndt, rt;
  assign ndt = -NW'(sq_side[RtW-1].dt);
  assign rt  = $signed(NW'(sq_root));

  always_ff @(posedge clk) begin
    if (en) begin
      n1_side <= sq_side[RtW-1];
      n1_lo   <= ndt - rt;
      n1_hi   <= ndt + rt;
    end
  end

  // Magnitudes, signs and saturation: |n| >= 4a puts the quotient outside any window.
  logic n2_v;
  ssfh_pkg::side_t n2_side;
  ssfh_pkg::div_tag_t n2_tag;
  logic [NW-1:0] mag_lo, mag_hi, four_a;
  logic [SW-1:0] n2_lo_hi, n2_hi_hi;
  logic [QW-1:0] n2_lo_lo, n2_hi_lo;

  always_comb begin
    mag_lo = n1_lo[NW-1] ? -n1_lo : n1_lo;
    mag_hi = n1_hi[NW-1] ? -n1_hi : n1_hi;
    four_a = {n1_side.a, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2_side        <= n1_side;
      n2_tag.lo_neg  <= n1_lo[NW-1];
      n2_tag.hi_neg  <= n1_hi[NW-1];
      n2_tag.lo_sat  <= mag_lo >= four_a;
      n2_tag.hi_sat  <= mag_hi >= four_a;
      n2_lo_hi       <= mag_lo[NW-1:2];
      n2_hi_hi       <= mag_hi[NW-1:2];
      n2_lo_lo       <= {mag_lo[1:0], {(QW-2){1'b0}}};
      n2_hi_lo       <= {mag_hi[1:0], {(QW-2){1'b0}}};
    end
  end

  logic [QW-1:0] q_lo, q_hi;
  logic          rnz_lo, rnz_hi;

  ssfh_div u_div_lo (
    .clk    (clk),
    .en     (en),
    .num_hi (n2_lo_hi),
    .num_lo (n2_lo_lo),
    .den    (n2_side.a),
    .quot   (q_lo),
    .rem_nz (rnz_lo)
  );

  ssfh_div u_div_hi (
    .clk    (clk),
    .en     (en),
    .num_hi (n2_hi_hi),
    .num_lo (n2_hi_lo),
    .den    (n2_side.a),
    .quot   (q_hi),
    .rem_nz (rnz_hi)
  );

  ssfh_pkg::side_t    dv_side [QW];
  ssfh_pkg::div_tag_t dv_tag  [QW];
  logic [QW-1:0]      dv_v;

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side[0] <= n2_side;
      dv_tag[0]  <= n2_tag;
      for (int k = 1; k < QW; k++) begin
        dv_side[k] <= dv_side[k-1];
        dv_tag[k]  <= dv_tag[k-1];
      end
    end
  end

  // Signed Q4.30 root: floor rounding, saturation, and the all-ones quotient of a zero divisor.
  function automatic logic signed [TW-1:0] form_param(input logic [QW-1:0] q,
                                                      input logic rnz, input logic neg,
                                                      input logic sat, input logic az);
    logic signed [TW-1:0] qx;
    qx = $signed(TW'(q));
    if (az) begin
      return -TW'(1);
    end else if (sat) begin
      return neg ? -$signed(TW'(1) << QW) : $signed(TW'(1) << QW);
    end else if (neg) begin
      return -(qx + $signed(TW'(rnz)));
    end
    return qx;
  endfunction

  logic q_v;
  ssfh_pkg::side_t q_side;
  logic signed [TW-1:0] q_tlo, q_thi;

  always_ff @(posedge clk) begin
    if (en) begin
      q_side <= dv_side[QW-1];
      q_tlo  <= form_param(q_lo, rnz_lo, dv_tag[QW-1].lo_neg, dv_tag[QW-1].lo_sat,
                           dv_side[QW-1].az);
      q_thi  <= form_param(q_hi, rnz_hi, dv_tag[QW-1].hi_neg, dv_tag[QW-1].hi_sat,
                           dv_side[QW-1].az);
    end
  end

  // Root window and choice of hit parameter.
  logic signed [TW-1:0] w_lo, w_hi, t_sel;
  logic sel_hit, sel_start;

  always_comb begin
    w_lo      = -$signed(TW'(margin));
    w_hi      = $signed(TW'(high));
    sel_hit   = 1'b0;
    sel_start = 1'b0;
    t_sel     = q_tlo;
    if (q_side.deg) begin
      sel_hit   = q_side.in0;
      sel_start = 1'b1;
    end else if (!q_side.dneg) begin
      sel_hit = !((q_thi < w_lo) || (q_tlo > w_hi));
      if (q_tlo < w_lo) begin
        t_sel     = q_thi;
        sel_start = (q_thi > w_hi);
      end
    end
  end

  logic w_v;
  logic signed [CW-1:0] w_s [3];
  logic signed [DW-1:0] w_d [3];
  logic signed [CW-1:0] w_t;
  logic w_hit, w_start;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        w_s[i] <= q_side.s[i];
        w_d[i] <= q_side.d[i];
      end
      w_t     <= t_sel[CW-1:0];
      w_hit   <= sel_hit;
      w_start <= sel_start;
    end
  end

  // Offset along the segment.
  logic m_v;
  logic signed [CW-1:0] m_s [3];
  logic signed [MW-1:0] m_p [3];
  logic m_hit, m_start;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m_s[i] <= w_s[i];
        m_p[i] <= w_d[i] * w_t;
      end
      m_hit   <= w_hit;
      m_start <= w_start;
    end
  end

  // Rounding, clamping and output register.
  logic signed [MW-1:0] pr [3];
  logic signed [VW-1:0] pos [3];
  logic signed [CW-1:0] pos_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr[i]  = (m_p[i] + RoundHalf) >>> 30;
      pos[i] = VW'(m_s[i]) + pr[i][VW-1:0];
      if (!m_hit) begin
        pos_c[i] = '0;
      end else if (m_start) begin
        pos_c[i] = m_s[i];
      end else if (pos[i] > PosMax) begin
        pos_c[i] = PosMax[CW-1:0];
      end else if (pos[i] < NegMin) begin
        pos_c[i] = NegMin[CW-1:0];
      end else begin
        pos_c[i] = pos[i][CW-1:0];
      end
    end
  end

  logic o_hit;
  logic signed [CW-1:0] o_pos [3];

  always_ff @(posedge clk) begin
    if (en) begin
      o_hit <= m_hit;
      o_pos <= pos_c;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      v6   <= 1'b0;
      v7   <= 1'b0;
      sq_v <= '0;
      n1_v <= 1'b0;
      n2_v <= 1'b0;
      dv_v <= '0;
      q_v  <= 1'b0;
      w_v  <= 1'b0;
      m_v  <= 1'b0;
      o_v  <= 1'b0;
    end else if (en) begin
      v1   <= query.valid;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      v6   <= v5;
      v7   <= v6;
      sq_v <= {sq_v[RtW-2:0], v7};
      n1_v <= sq_v[RtW-1];
      n2_v <= n1_v;
      dv_v <= {dv_v[QW-2:0], n2_v};
      q_v  <= dv_v[QW-1];
      w_v  <= q_v;
      m_v  <= w_v;
      o_v  <= m_v;
    end
  end

  assign result.valid = o_v;
  assign result.hit   = o_hit;
  assign result.hit_x = o_pos[0];
  assign result.hit_y = o_pos[1];
  assign result.hit_z = o_pos[2];

`ifndef NO_ASSERTIONS
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.hit |->
      result.hit_x == '0 && result.hit_y == '0 && result.hit_z == '0)
    else $error("miss result carries a non-zero point");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    query.ready == (!result.valid || result.ready))
    else $error("request ready does not follow the output stall");

  a_window: assert property (@(posedge clk) disable iff (rst)
    q_v && sel_hit && !sel_start |-> t_sel >= w_lo && t_sel <= w_hi)
    else $error("chosen root parameter outside the accepted window");
`endif

endmodule
`default_nettype wire

/* design/ssfh_sqrt.sv */
// Pipelined floor square root, one result bit per stage.
`default_nettype none
module ssfh_sqrt (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [ssfh_pkg::DiscW-1:0]   radicand,
  output logic      [ssfh_pkg::RootW-1:0]   root
);
  localparam int Steps = ssfh_pkg::RootW;
  localparam int RemW  = ssfh_pkg::RootW + 2;
  localparam int DW    = ssfh_pkg::DiscW;

  logic [RemW-1:0]  rem_q  [Steps];
  logic [Steps-1:0] root_q [Steps];
  logic [DW-1:0]    rad_q  [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [RemW-1:0]  rem_in;
    logic [Steps-1:0] root_in;
    logic [DW-1:0]    rad_in;
    logic [RemW-1:0]  r2;
    logic [RemW-1:0]  trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = radicand;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    always_comb begin
      r2    = {rem_in[RemW-3:0], rad_in[DW-1 -: 2]};
      trial = {root_in, 2'b01};
      ge    = (r2 >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? (r2 - trial) : r2;
        root_q[k] <= {root_in[Steps-2:0], ge};
        rad_q[k]  <= {rad_in[DW-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[Steps-1];

endmodule
`default_nettype wire

/* design/ssfh_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with a remainder flag.
`default_nettype none
module ssfh_div (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [ssfh_pkg::SumW-1:0]   num_hi,
  input  wire logic [ssfh_pkg::QuotW-1:0]  num_lo,
  input  wire logic [ssfh_pkg::SumW-1:0]   den,
  output logic      [ssfh_pkg::QuotW-1:0]  quot,
  output logic                             rem_nz
);
  localparam int Steps = ssfh_pkg::QuotW;
  localparam int RW    = ssfh_pkg::SumW;

  logic [RW-1:0]    r_q   [Steps];
  logic [Steps-1:0] q_q   [Steps];
  logic [Steps-1:0] lo_q  [Steps];
  logic [RW-1:0]    den_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [RW-1:0]    r_in;
    logic [Steps-1:0] q_in;
    logic [Steps-1:0] lo_in;
    logic [RW-1:0]    den_in;
    logic [RW:0]      r2;
    logic [RW:0]      diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign r_in   = num_hi;
      assign q_in   = '0;
      assign lo_in  = num_lo;
      assign den_in = den;
    end else begin : g_next
      assign r_in   = r_q[k-1];
      assign q_in   = q_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign den_in = den_q[k-1];
    end

    always_comb begin
      r2   = {r_in, lo_in[Steps-1]};
      diff = r2 - {1'b0, den_in};
      ge   = (r2 >= {1'b0, den_in});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_q[k]   <= ge ? diff[RW-1:0] : r2[RW-1:0];
        q_q[k]   <= {q_in[Steps-2:0], ge};
        lo_q[k]  <= {lo_in[Steps-2:0], 1'b0};
        den_q[k] <= den_in;
      end
    end
  end

  assign quot   = q_q[Steps-1];
  assign rem_nz = |r_q[Steps-1];

endmodule
`default_nettype wire
